FILE: hw/rtl/rcsd_pkg.sv
// ----------------------------------------------------------------------------
// rcsd_pkg: shared types and constants of the rc stick command decoder
// Stick codes, command patterns, action codes, register indexes and the
// frame, result, configuration and hold-state structures.
// ----------------------------------------------------------------------------
package rcsd_pkg;

	// stick classification codes: {above min, below max}
	localparam logic [1:0] CODE_LO = 2'b01;
	localparam logic [1:0] CODE_CE = 2'b11;
	localparam logic [1:0] CODE_HI = 2'b10;

	// command patterns: {throttle, yaw, pitch, roll}
	localparam logic [7:0] PAT_DISARM    = {CODE_LO, CODE_LO, CODE_CE, CODE_CE};
	localparam logic [7:0] PAT_GYRO_CAL  = {CODE_LO, CODE_LO, CODE_LO, CODE_CE};
	localparam logic [7:0] PAT_PROFILE_0 = {CODE_LO, CODE_LO, CODE_CE, CODE_LO};
	localparam logic [7:0] PAT_PROFILE_1 = {CODE_LO, CODE_LO, CODE_HI, CODE_CE};
	localparam logic [7:0] PAT_PROFILE_2 = {CODE_LO, CODE_LO, CODE_CE, CODE_HI};
	localparam logic [7:0] PAT_SAVE      = {CODE_LO, CODE_LO, CODE_LO, CODE_HI};
	localparam logic [7:0] PAT_ARM       = {CODE_LO, CODE_HI, CODE_CE, CODE_CE};
	localparam logic [7:0] PAT_ACC_CAL   = {CODE_HI, CODE_LO, CODE_LO, CODE_CE};
	localparam logic [7:0] PAT_MAG_CAL   = {CODE_HI, CODE_HI, CODE_LO, CODE_CE};
	localparam logic [7:0] PAT_TRIM_PDN  = {CODE_HI, CODE_CE, CODE_HI, CODE_CE};
	localparam logic [7:0] PAT_TRIM_PUP  = {CODE_HI, CODE_CE, CODE_LO, CODE_CE};
	localparam logic [7:0] PAT_TRIM_RDN  = {CODE_HI, CODE_CE, CODE_CE, CODE_HI};
	localparam logic [7:0] PAT_TRIM_RUP  = {CODE_HI, CODE_CE, CODE_CE, CODE_LO};

	// switch actions
	localparam logic [1:0] SW_NONE   = 2'd0;
	localparam logic [1:0] SW_ARM    = 2'd1;
	localparam logic [1:0] SW_DISARM = 2'd2;

	// stick actions
	localparam logic [3:0] ACT_NONE      = 4'd0;
	localparam logic [3:0] ACT_ARM       = 4'd1;
	localparam logic [3:0] ACT_DISARM    = 4'd2;
	localparam logic [3:0] ACT_BEEP      = 4'd3;
	localparam logic [3:0] ACT_GYRO_CAL  = 4'd4;
	localparam logic [3:0] ACT_PROFILE   = 4'd5;
	localparam logic [3:0] ACT_SAVE      = 4'd6;
	localparam logic [3:0] ACT_ACC_CAL   = 4'd7;
	localparam logic [3:0] ACT_MAG_CAL   = 4'd8;
	localparam logic [3:0] ACT_TRIM      = 4'd9;

	// trim step and hold counter reload after a trim
	localparam logic signed [2:0] TRIM_STEP_POS = 3'sd2;
	localparam logic signed [2:0] TRIM_STEP_NEG = -3'sd2;
	localparam logic [7:0]        TRIM_RELOAD   = 8'd10;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CHECK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CHECK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MID_VALUE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_3D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_3D     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STICKS_ARM  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KILL_SWITCH = 3'd6;

	typedef struct packed {
		logic [11:0] min_check;
		logic [11:0] max_check;
		logic [11:0] mid_value;
		logic [9:0]  deadband_3d;
		logic        mode_3d;
		logic        sticks_arm;
		logic        kill_switch;
	} cfg_t;

	typedef struct packed {
		logic [11:0] roll_value;
		logic [11:0] pitch_value;
		logic [11:0] yaw_value;
		logic [11:0] throttle_value;
		logic        arm_switch_on;
		logic        is_armed;
		logic        arm_allowed;
		logic        rx_signal_ok;
		logic        failsafe_on;
	} frame_t;

	typedef struct packed {
		logic [1:0]        switch_action;
		logic [3:0]        stick_action;
		logic [1:0]        profile_index;
		logic signed [2:0] trim_roll_delta;
		logic signed [2:0] trim_pitch_delta;
	} result_t;

	// pattern and hold counter carried from frame to frame
	typedef struct packed {
		logic [7:0] pattern;
		logic [7:0] count;
	} hold_state_t;

endpackage

FILE: hw/rtl/rcsd_if.sv
// ----------------------------------------------------------------------------
// rcsd_if: handshake channels of the rc stick command decoder
// Frame channel into the block and result channel out of it, each with
// valid, ready and the word's fields.
// ----------------------------------------------------------------------------
interface rcsd_frame_if;
	logic        valid;
	logic        ready;
	logic [11:0] roll_value;
	logic [11:0] pitch_value;
	logic [11:0] yaw_value;
	logic [11:0] throttle_value;
	logic        arm_switch_on;
	logic        is_armed;
	logic        arm_allowed;
	logic        rx_signal_ok;
	logic        failsafe_on;

	modport source (
		output valid, roll_value, pitch_value, yaw_value, throttle_value,
		output arm_switch_on, is_armed, arm_allowed, rx_signal_ok, failsafe_on,
		input  ready
	);
	modport sink (
		input  valid, roll_value, pitch_value, yaw_value, throttle_value,
		input  arm_switch_on, is_armed, arm_allowed, rx_signal_ok, failsafe_on,
		output ready
	);
endinterface

interface rcsd_result_if;
	logic              valid;
	logic              ready;
	logic [1:0]        switch_action;
	logic [3:0]        stick_action;
	logic [1:0]        profile_index;
	logic signed [2:0] trim_roll_delta;
	logic signed [2:0] trim_pitch_delta;

	modport source (
		output valid, switch_action, stick_action, profile_index,
		output trim_roll_delta, trim_pitch_delta,
		input  ready
	);
	modport sink (
		input  valid, switch_action, stick_action, profile_index,
		input  trim_roll_delta, trim_pitch_delta,
		output ready
	);
endinterface

FILE: hw/rtl/rcsd_decode.sv
// ----------------------------------------------------------------------------
// rcsd_decode: per-frame decode logic
// Classifies the sticks, advances the hold counter, decides the switch
// request and the stick command, and returns the next hold state.
// ----------------------------------------------------------------------------
module rcsd_decode #(
	parameter int FIRE_COUNT = 20,
	parameter int COUNT_CAP  = 250
) (
	input  rcsd_pkg::cfg_t        cfg,
	input  rcsd_pkg::frame_t      frame,
	input  rcsd_pkg::hold_state_t hold_cur,
	output rcsd_pkg::result_t     result,
	output rcsd_pkg::hold_state_t hold_nxt
);

	localparam logic [7:0] FIRE_VAL = 8'(FIRE_COUNT);
	localparam logic [7:0] CAP_VAL  = 8'(COUNT_CAP);

	logic [7:0]         pat;
	logic [7:0]         cnt;
	logic               armed;
	logic               thr_low;
	logic signed [13:0] thr_s;
	logic signed [13:0] band_lo;
	logic signed [13:0] band_hi;

	function automatic logic [1:0] stick_code(input logic [11:0] v, input rcsd_pkg::cfg_t c);
		stick_code = {v > c.min_check, v < c.max_check};
	endfunction

	// throttle-low detection, 3d band is open on both ends
	always_comb begin
		thr_s   = $signed({2'b00, frame.throttle_value});
		band_lo = $signed({2'b00, cfg.mid_value}) - $signed({4'b0000, cfg.deadband_3d});
		band_hi = $signed({2'b00, cfg.mid_value}) + $signed({4'b0000, cfg.deadband_3d});
		if (cfg.mode_3d) begin
			thr_low = (thr_s > band_lo) && (thr_s < band_hi);
		end else begin
			thr_low = frame.throttle_value < cfg.min_check;
		end
	end

	// pattern, hold counter, switch request and stick command
	always_comb begin
		pat = {stick_code(frame.throttle_value, cfg), stick_code(frame.yaw_value, cfg),
			stick_code(frame.pitch_value, cfg), stick_code(frame.roll_value, cfg)};

		if (pat == hold_cur.pattern) begin
			cnt = (hold_cur.count < CAP_VAL) ? hold_cur.count + 8'd1 : hold_cur.count;
		end else begin
			cnt = 8'd0;
		end

		result.switch_action    = rcsd_pkg::SW_NONE;
		result.stick_action     = rcsd_pkg::ACT_NONE;
		result.profile_index    = 2'd0;
		result.trim_roll_delta  = 3'sd0;
		result.trim_pitch_delta = 3'sd0;
		armed = frame.is_armed;

		// switch arming, seen by the stick commands of the same frame
		if (!cfg.sticks_arm) begin
			if (frame.arm_switch_on) begin
				if (thr_low && frame.arm_allowed) begin
					result.switch_action = rcsd_pkg::SW_ARM;
					armed = 1'b1;
				end
			end else if (armed && frame.rx_signal_ok && !frame.failsafe_on) begin
				if (cfg.kill_switch || thr_low) begin
					result.switch_action = rcsd_pkg::SW_DISARM;
					armed = 1'b0;
				end
			end
		end

		// combinations fire at the fire count; trims and beep reload and repeat
		if (cnt == FIRE_VAL) begin
			if (cfg.sticks_arm && pat == rcsd_pkg::PAT_DISARM) begin
				if (armed) begin
					result.stick_action = rcsd_pkg::ACT_DISARM;
				end else begin
					result.stick_action = rcsd_pkg::ACT_BEEP;
					cnt = 8'd0;
				end
			end else if (!armed) begin
				case (pat)
					rcsd_pkg::PAT_GYRO_CAL: result.stick_action = rcsd_pkg::ACT_GYRO_CAL;
					rcsd_pkg::PAT_PROFILE_0: begin
						result.stick_action  = rcsd_pkg::ACT_PROFILE;
						result.profile_index = 2'd0;
					end
					rcsd_pkg::PAT_PROFILE_1: begin
						result.stick_action  = rcsd_pkg::ACT_PROFILE;
						result.profile_index = 2'd1;
					end
					rcsd_pkg::PAT_PROFILE_2: begin
						result.stick_action  = rcsd_pkg::ACT_PROFILE;
						result.profile_index = 2'd2;
					end
					rcsd_pkg::PAT_SAVE: result.stick_action = rcsd_pkg::ACT_SAVE;
					rcsd_pkg::PAT_ARM: begin
						if (cfg.sticks_arm) begin
							result.stick_action = rcsd_pkg::ACT_ARM;
						end
					end
					rcsd_pkg::PAT_ACC_CAL: result.stick_action = rcsd_pkg::ACT_ACC_CAL;
					rcsd_pkg::PAT_MAG_CAL: result.stick_action = rcsd_pkg::ACT_MAG_CAL;
					rcsd_pkg::PAT_TRIM_PDN: begin
						result.stick_action     = rcsd_pkg::ACT_TRIM;
						result.trim_pitch_delta = rcsd_pkg::TRIM_STEP_NEG;
						cnt = rcsd_pkg::TRIM_RELOAD;
					end
					rcsd_pkg::PAT_TRIM_PUP: begin
						result.stick_action     = rcsd_pkg::ACT_TRIM;
						result.trim_pitch_delta = rcsd_pkg::TRIM_STEP_POS;
						cnt = rcsd_pkg::TRIM_RELOAD;
					end
					rcsd_pkg::PAT_TRIM_RDN: begin
						result.stick_action    = rcsd_pkg::ACT_TRIM;
						result.trim_roll_delta = rcsd_pkg::TRIM_STEP_NEG;
						cnt = rcsd_pkg::TRIM_RELOAD;
					end
					rcsd_pkg::PAT_TRIM_RUP: begin
						result.stick_action    = rcsd_pkg::ACT_TRIM;
						result.trim_roll_delta = rcsd_pkg::TRIM_STEP_POS;
						cnt = rcsd_pkg::TRIM_RELOAD;
					end
					default: result.stick_action = rcsd_pkg::ACT_NONE;
				endcase
			end
		end

		hold_nxt.pattern = pat;
		hold_nxt.count   = cnt;
	end

endmodule

FILE: hw/rtl/rc_stick_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// rc_stick_command_decoder_unit: rc stick command decoder, top level
// Input register, single-pass decode, output register and config registers.
// ----------------------------------------------------------------------------
// One radio frame per clock unless the result channel stalls: a frame word is
// taken into the input register, decoded from there and written to the output
// register, which offers its result word. The frame-to-frame pattern and hold
// counter update with that register write, which sets the rate at one word per
// cycle. The output register parts the two channels: a new frame is taken into
// an empty input register while a finished result still waits. The user must
// write configuration through cfg_wr_en/cfg_index/cfg_data only while no frame
// is in flight (not enforced); indexes past the last register are ignored.
module rc_stick_command_decoder_unit #(
	parameter int FIRE_COUNT = 20,
	parameter int COUNT_CAP  = 250
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	rcsd_frame_if.sink                             frame_in,
	rcsd_result_if.source                          result_out,
	input  logic                                   cfg_wr_en,
	input  logic [rcsd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rcsd_pkg::CFG_DATA_W-1:0]        cfg_data
);

	rcsd_pkg::cfg_t        cfg_q;
	rcsd_pkg::frame_t      frame_s1;
	logic                  valid_s1;
	rcsd_pkg::result_t     result_q;
	logic                  out_valid_q;
	rcsd_pkg::hold_state_t hold_q;
	rcsd_pkg::hold_state_t hold_d;
	rcsd_pkg::result_t     result_d;
	logic                  advance;
	logic                  in_ready;

	assign advance  = valid_s1 && (!out_valid_q || result_out.ready);
	assign in_ready = !valid_s1 || advance;
	assign frame_in.ready = in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_check   <= 12'd1100;
			cfg_q.max_check   <= 12'd1900;
			cfg_q.mid_value   <= 12'd1500;
			cfg_q.deadband_3d <= 10'd50;
			cfg_q.mode_3d     <= 1'b0;
			cfg_q.sticks_arm  <= 1'b1;
			cfg_q.kill_switch <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rcsd_pkg::REG_MIN_CHECK:   cfg_q.min_check   <= cfg_data[11:0];
				rcsd_pkg::REG_MAX_CHECK:   cfg_q.max_check   <= cfg_data[11:0];
				rcsd_pkg::REG_MID_VALUE:   cfg_q.mid_value   <= cfg_data[11:0];
				rcsd_pkg::REG_DEADBAND_3D: cfg_q.deadband_3d <= cfg_data[9:0];
				rcsd_pkg::REG_MODE_3D:     cfg_q.mode_3d     <= cfg_data[0];
				rcsd_pkg::REG_STICKS_ARM:  cfg_q.sticks_arm  <= cfg_data[0];
				rcsd_pkg::REG_KILL_SWITCH: cfg_q.kill_switch <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_ready && frame_in.valid) begin
			frame_s1.roll_value     <= frame_in.roll_value;
			frame_s1.pitch_value    <= frame_in.pitch_value;
			frame_s1.yaw_value      <= frame_in.yaw_value;
			frame_s1.throttle_value <= frame_in.throttle_value;
			frame_s1.arm_switch_on  <= frame_in.arm_switch_on;
			frame_s1.is_armed       <= frame_in.is_armed;
			frame_s1.arm_allowed    <= frame_in.arm_allowed;
			frame_s1.rx_signal_ok   <= frame_in.rx_signal_ok;
			frame_s1.failsafe_on    <= frame_in.failsafe_on;
		end
	end

	rcsd_decode #(
		.FIRE_COUNT (FIRE_COUNT),
		.COUNT_CAP  (COUNT_CAP)
	) u_decode (
		.cfg      (cfg_q),
		.frame    (frame_s1),
		.hold_cur (hold_q),
		.result   (result_d),
		.hold_nxt (hold_d)
	);

	// hold state and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				hold_q <= hold_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_out.valid            = out_valid_q;
	assign result_out.switch_action    = result_q.switch_action;
	assign result_out.stick_action     = result_q.stick_action;
	assign result_out.profile_index    = result_q.profile_index;
	assign result_out.trim_roll_delta  = result_q.trim_roll_delta;
	assign result_out.trim_pitch_delta = result_q.trim_pitch_delta;

	// hold counter stays within its cap
	a_hold_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q.count <= 8'(COUNT_CAP))
		else $error("hold counter above cap");

	// a trim command reloads the hold counter
	a_trim_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result_d.stick_action == rcsd_pkg::ACT_TRIM)
		|=> hold_q.count == rcsd_pkg::TRIM_RELOAD)
		else $error("trim did not reload hold counter");

	// trim deltas only accompany a trim command
	a_trim_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.stick_action != rcsd_pkg::ACT_TRIM)
		|-> (result_q.trim_roll_delta == 3'sd0 && result_q.trim_pitch_delta == 3'sd0))
		else $error("trim delta without trim command");

	// a held result is not overwritten while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_out.ready) |=> (out_valid_q && $stable(result_q)))
		else $error("stalled result changed");

endmodule
